// ===== rtl/sf3_pkg.sv =====
// Shared constants, types and the per-pixel decision function for the
// 3x3 speckle filter. No dependencies.
package sf3_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int PIXEL_BITS = 16;
    localparam int MIN_SIZE   = 3;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int VAL_W   = 16;
    localparam int THR_W   = 16;
    localparam int MINN_W  = 4;
    localparam int NCOLS_W = 11;
    localparam int NROWS_W = 13;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;
    typedef logic signed [VAL_W-1:0]      val_t;
    typedef logic signed [THR_W-1:0]      thr_t;
    typedef logic [COL_W-1:0]             col_t;
    typedef logic [COL_W:0]               col_ext_t;
    typedef logic [ROW_W-1:0]             row_t;
    typedef logic [ROW_W:0]               row_ext_t;
    typedef logic [2*PIXEL_BITS-1:0]      line_word_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_KEEP_COUNT = 2'd1,
        REG_NUM_COLS   = 2'd2,
        REG_NUM_ROWS   = 2'd3
    } reg_idx_t;

    // Neighborhood as seen by the decision logic. win[0..2] is column c-2
    // (top, middle, bottom), win[3..5] is column c-1; top and mid come from
    // the line memory for column c.
    typedef struct packed {
        pix_t [5:0] win;
        pix_t       top;
        pix_t       mid;
    } nbhd_t;

    function automatic logic above(input pix_t v, input thr_t thr);
        above = v > thr;
    endfunction

    function automatic val_t filter_pixel(input nbhd_t n, input pix_t bot,
                                          input thr_t thr,
                                          input logic [MINN_W-1:0] min_n);
        logic [7:0] flags;
        logic [3:0] cnt;
        begin
            flags = {above(n.win[0], thr), above(n.win[1], thr),
                     above(n.win[2], thr), above(n.win[3], thr),
                     above(n.win[5], thr), above(n.top, thr),
                     above(n.mid, thr), above(bot, thr)};
            cnt = 4'd0;
            for (int i = 0; i < 8; i++) begin
                cnt = cnt + {3'b000, flags[i]};
            end
            if (above(n.win[4], thr) && (cnt < min_n)) begin
                filter_pixel = val_t'(thr);
            end else begin
                filter_pixel = val_t'(n.win[4]);
            end
        end
    endfunction

endpackage

// ===== rtl/speckle_filter_3x3.sv =====
// Top level of the 3x3 neighbor-count speckle filter: APB register file,
// raster position counters, pipeline control and output register.
// Depends on sf3_pkg and sf3_nbhd.
//
// Usage. Pixels of a reflectivity image enter on the s_ channel in raster
// order, one request per pixel, signed in 1/16 dB. For each interior pixel
// the filter sends one request on the m_ channel with the filtered value and
// its row and column. A center above the threshold with fewer than keep count
// of its eight neighbors above the threshold is replaced by the threshold;
// border pixels produce no request.
// The result for pixel (r-1, c-1) is registered as pixel (r, c) leaves the
// second stage. Throughput is one pixel per clock unless the receiver stalls;
// the limit is the single read and single write per cycle of the line
// memory, which is read when a pixel is accepted and written one stage
// later. When the receiver stalls, one more pixel is still accepted into the
// second stage; further pixels wait until the output register drains. A
// pixel whose window is incomplete passes the second stage without waiting
// on the receiver, unless a blocked result sits there ahead of it.
// Reset (aresetn low, synchronous) clears the position to row 0, column 0,
// clears the window registers and loads the register defaults (threshold 0,
// keep count 0, 1024 columns, 4096 rows). The line memory is not
// cleared; words read before they are written only feed border pixels.
// Registers, at byte addresses 0, 4, 8, 12: threshold, keep count,
// num_cols, num_rows. Write them only while the filter is idle.
module speckle_filter_3x3 (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sf3_pkg::APB_AW-1:0]    paddr,
    input  logic [sf3_pkg::APB_DW-1:0]    pwdata,
    output logic [sf3_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // Pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sf3_pkg::pix_t                 s_pixel,
    // Filtered output
    output logic                          m_valid,
    input  logic                          m_ready,
    output sf3_pkg::val_t                 m_value,
    output sf3_pkg::row_t                 m_row,
    output sf3_pkg::col_t                 m_col
);

    // Configuration registers
    logic [sf3_pkg::THR_W-1:0]   threshold_reg;
    logic [sf3_pkg::MINN_W-1:0]  keep_count_reg;
    logic [sf3_pkg::NCOLS_W-1:0] num_cols_reg;
    logic [sf3_pkg::NROWS_W-1:0] num_rows_reg;
    sf3_pkg::reg_idx_t           reg_idx;
    logic                        cfg_wr;

    // Position counters
    sf3_pkg::col_t     col_reg;
    sf3_pkg::col_t     col_next;
    sf3_pkg::row_t     row_reg;
    sf3_pkg::row_t     row_next;
    sf3_pkg::col_ext_t cols_eff;
    sf3_pkg::row_ext_t rows_eff;
    sf3_pkg::col_ext_t col_inc;
    sf3_pkg::row_ext_t row_inc;

    // Second stage
    logic              p1_valid_reg;
    logic              p1_emit_reg;
    sf3_pkg::col_t     p1_addr_reg;
    sf3_pkg::pix_t     p1_pixel_reg;
    sf3_pkg::row_t     p1_row_reg;
    sf3_pkg::col_t     p1_col_reg;
    logic              p1_adv;
    logic              s_acc;

    // Output register
    logic              m_valid_reg;
    sf3_pkg::val_t     m_value_reg;
    sf3_pkg::row_t     m_row_reg;
    sf3_pkg::col_t     m_col_reg;

    sf3_pkg::nbhd_t    nbhd;
    sf3_pkg::val_t     filt_value;

    // ------------------------------------------------------------------
    // APB register file. Address bits below the word are ignored.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = sf3_pkg::reg_idx_t'(paddr[sf3_pkg::APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= '0;
            keep_count_reg <= '0;
            num_cols_reg   <= sf3_pkg::NCOLS_W'(1024);
            num_rows_reg   <= sf3_pkg::NROWS_W'(4096);
        end else if (cfg_wr) begin
            case (reg_idx)
                sf3_pkg::REG_THRESHOLD: begin
                    threshold_reg <= pwdata[sf3_pkg::THR_W-1:0];
                end
                sf3_pkg::REG_KEEP_COUNT: begin
                    keep_count_reg <= pwdata[sf3_pkg::MINN_W-1:0];
                end
                sf3_pkg::REG_NUM_COLS: begin
                    num_cols_reg <= pwdata[sf3_pkg::NCOLS_W-1:0];
                end
                sf3_pkg::REG_NUM_ROWS: begin
                    num_rows_reg <= pwdata[sf3_pkg::NROWS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sf3_pkg::REG_THRESHOLD:  prdata = sf3_pkg::APB_DW'(threshold_reg);
            sf3_pkg::REG_KEEP_COUNT: prdata = sf3_pkg::APB_DW'(keep_count_reg);
            sf3_pkg::REG_NUM_COLS:   prdata = sf3_pkg::APB_DW'(num_cols_reg);
            sf3_pkg::REG_NUM_ROWS:   prdata = sf3_pkg::APB_DW'(num_rows_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Image size, saturated to the supported range.
    // ------------------------------------------------------------------
    always_comb begin
        if (32'(num_cols_reg) > sf3_pkg::MAX_COLS) begin
            cols_eff = sf3_pkg::col_ext_t'(sf3_pkg::MAX_COLS);
        end else if (32'(num_cols_reg) < sf3_pkg::MIN_SIZE) begin
            cols_eff = sf3_pkg::col_ext_t'(sf3_pkg::MIN_SIZE);
        end else begin
            cols_eff = sf3_pkg::col_ext_t'(num_cols_reg);
        end
        if (32'(num_rows_reg) > sf3_pkg::MAX_ROWS) begin
            rows_eff = sf3_pkg::row_ext_t'(sf3_pkg::MAX_ROWS);
        end else if (32'(num_rows_reg) < sf3_pkg::MIN_SIZE) begin
            rows_eff = sf3_pkg::row_ext_t'(sf3_pkg::MIN_SIZE);
        end else begin
            rows_eff = sf3_pkg::row_ext_t'(num_rows_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A pixel whose window is incomplete leaves the second
    // stage without touching the output register.
    // ------------------------------------------------------------------
    assign p1_adv  = p1_valid_reg && (!p1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign s_acc   = s_valid && s_ready;

    // Raster position. A size change between frames or mid-frame simply
    // wraps the counters once they reach the new size.
    always_comb begin
        col_inc  = sf3_pkg::col_ext_t'(col_reg) + sf3_pkg::col_ext_t'(1);
        row_inc  = sf3_pkg::row_ext_t'(row_reg) + sf3_pkg::row_ext_t'(1);
        col_next = col_inc[sf3_pkg::COL_W-1:0];
        row_next = row_reg;
        if (col_inc >= cols_eff) begin
            col_next = '0;
            if (row_inc >= rows_eff) begin
                row_next = '0;
            end else begin
                row_next = row_inc[sf3_pkg::ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Second stage: holds the accepted pixel while the line memory read
    // completes. The write back happens when it leaves this stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_emit_reg  <= (row_reg >= sf3_pkg::row_t'(2)) &&
                            (col_reg >= sf3_pkg::col_t'(2));
            p1_addr_reg  <= col_reg;
            p1_pixel_reg <= s_pixel;
            p1_row_reg   <= row_reg - sf3_pkg::row_t'(1);
            p1_col_reg   <= col_reg - sf3_pkg::col_t'(1);
        end
    end

    sf3_nbhd u_nbhd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .wr_en   (p1_adv),
        .wr_addr (p1_addr_reg),
        .wr_bot  (p1_pixel_reg),
        .nbhd    (nbhd)
    );

    assign filt_value = sf3_pkg::filter_pixel(nbhd, p1_pixel_reg,
                                              sf3_pkg::thr_t'(threshold_reg),
                                              keep_count_reg);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv && p1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_emit_reg) begin
            m_value_reg <= filt_value;
            m_row_reg   <= p1_row_reg;
            m_col_reg   <= p1_col_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_row   = m_row_reg;
    assign m_col   = m_col_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The line memory is never read and written at the same column in one
    // cycle, so no forwarding is needed.
    a_no_mem_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && p1_adv) |-> (col_reg != p1_addr_reg))
        else $error("line memory read and write hit the same column");

    // Input back-pressure only comes from a blocked result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && p1_emit_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // A result leaving the second stage always lands in the output register.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_adv && p1_emit_reg) |=> m_valid_reg)
        else $error("result dropped between stage and output register");

    // Reported pixels never lie in row 0 or column 0.
    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_row != '0) && (m_col != '0)))
        else $error("border pixel reported");

endmodule

// ===== rtl/sf3_nbhd.sv =====
// Line memory (two previous rows, one word per column) and the 3x3 window
// registers of the speckle filter. Depends on sf3_pkg.
module sf3_nbhd (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  sf3_pkg::col_t       rd_addr,
    input  logic                wr_en,
    input  sf3_pkg::col_t       wr_addr,
    input  sf3_pkg::pix_t       wr_bot,
    output sf3_pkg::nbhd_t      nbhd
);

    // Each word holds {row r-2, row r-1} for one column.
    sf3_pkg::line_word_t line_mem [sf3_pkg::MAX_COLS];
    sf3_pkg::line_word_t rd_data_reg;
    sf3_pkg::pix_t       win_reg [6];
    sf3_pkg::pix_t       top;
    sf3_pkg::pix_t       mid;

    assign top = rd_data_reg[2*sf3_pkg::PIXEL_BITS-1:sf3_pkg::PIXEL_BITS];
    assign mid = rd_data_reg[sf3_pkg::PIXEL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= {mid, wr_bot};
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (wr_en) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= wr_bot;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            nbhd.win[i] = win_reg[i];
        end
        nbhd.top = top;
        nbhd.mid = mid;
    end

endmodule
